>>> src/running_median_two_heaps_defines.svh
// ----------------------------------------------------------------------------
// running_median_two_heaps_defines
// Assertion macros for the running median block. They expand to nothing in
// synthesis.
// ----------------------------------------------------------------------------
`ifndef RUNNING_MEDIAN_TWO_HEAPS_DEFINES_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_DEFINES_SVH
`ifndef SYNTHESIS
// check a property while out of reset
`define RMH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("running median check failed");
// check a property at every edge, reset included
`define RMH_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("running median reset check failed");
`else
`define RMH_ASSERT(lbl, prop)
`define RMH_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> src/rmh_pkg.sv
// ----------------------------------------------------------------------------
// rmh_pkg
// Types, constants and helpers shared by the running median controller,
// datapath and top level.
// ----------------------------------------------------------------------------
package rmh_pkg;

  localparam int CAPACITY   = 1024;
  localparam int HEAP_DEPTH = CAPACITY / 2 + 1;
  localparam int IDX_W      = $clog2(HEAP_DEPTH);
  localparam int COUNT_W    = 11;

  // heap selection
  localparam logic SIDE_LOWER = 1'b0;
  localparam logic SIDE_UPPER = 1'b1;

  // push phases of one sample
  localparam logic [1:0] PH_PLAIN = 2'd0;
  localparam logic [1:0] PH_MOVED = 2'd1;
  localparam logic [1:0] PH_FINAL = 2'd2;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               new_stream;
  } sample_t;

  typedef struct packed {
    logic signed [31:0]  running_median;
    logic [COUNT_W-1:0]  stored_count;
    logic                dropped;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_POP_TOP,
    S_POP_LOAD,
    S_POP_RD,
    S_POP_CMP,
    S_PUSH_INIT,
    S_PUSH_RD,
    S_PUSH_CMP,
    S_FIN_RD,
    S_FIN_CALC
  } state_t;

  typedef struct packed {
    logic side;
    logic load;
    logic decide;
    logic pop_top;
    logic pop_load;
    logic pop_rd;
    logic pop_cmp;
    logic push_init;
    logic push_src_t;
    logic push_rd;
    logic push_cmp;
    logic fin_rd;
    logic fin_calc;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic gt;
    logic l_gt_u;
    logic u_gt_l;
    logic pop_done;
    logic push_root;
    logic push_stop;
    logic out_free;
  } status_t;

  // a must sit above b: max order for the lower heap, min order for the upper
  function automatic logic above(logic signed [31:0] a, logic signed [31:0] b,
                                 logic side);
    above = (side == SIDE_UPPER) ? (a < b) : (a > b);
  endfunction

endpackage

>>> src/rmh_ctrl.sv
// ----------------------------------------------------------------------------
// rmh_ctrl
// Sequencer for one sample: decide, optional pop and cross move, pushes,
// top read and median update.
// ----------------------------------------------------------------------------
module rmh_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  input  rmh_pkg::status_t status,
  output rmh_pkg::cmd_t    cmd,
  output logic             busy
);
  import rmh_pkg::*;

  state_t     state, state_next;
  logic       side, side_next;
  logic [1:0] phase, phase_next;

  // hold state, side and phase
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      side  <= SIDE_LOWER;
      phase <= PH_PLAIN;
    end else begin
      state <= state_next;
      side  <= side_next;
      phase <= phase_next;
    end
  end

  assign busy = (state != S_IDLE);

  // next state and commands
  always_comb begin
    cmd        = '0;
    cmd.side   = side;
    state_next = state;
    side_next  = side;
    phase_next = phase;
    case (state)
      S_IDLE: begin
        if (sample_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        phase_next = PH_PLAIN;
        if (status.full) begin
          state_next = S_FIN_CALC;
        end else if (status.l_gt_u) begin
          if (status.gt) begin
            side_next  = SIDE_UPPER;
            state_next = S_PUSH_INIT;
          end else begin
            side_next  = SIDE_LOWER;
            state_next = S_POP_TOP;
          end
        end else if (status.u_gt_l) begin
          if (status.gt) begin
            side_next  = SIDE_UPPER;
            state_next = S_POP_TOP;
          end else begin
            side_next  = SIDE_LOWER;
            state_next = S_PUSH_INIT;
          end
        end else begin
          side_next  = status.gt ? SIDE_UPPER : SIDE_LOWER;
          state_next = S_PUSH_INIT;
        end
      end
      S_POP_TOP: begin
        cmd.pop_top = 1'b1;
        state_next  = S_POP_LOAD;
      end
      S_POP_LOAD: begin
        cmd.pop_load = 1'b1;
        state_next   = S_POP_RD;
      end
      S_POP_RD: begin
        cmd.pop_rd = 1'b1;
        state_next = S_POP_CMP;
      end
      S_POP_CMP: begin
        cmd.pop_cmp = 1'b1;
        if (status.pop_done) begin
          side_next  = ~side;
          phase_next = PH_MOVED;
          state_next = S_PUSH_INIT;
        end else begin
          state_next = S_POP_RD;
        end
      end
      S_PUSH_INIT: begin
        cmd.push_init  = 1'b1;
        cmd.push_src_t = (phase == PH_MOVED);
        state_next     = S_PUSH_RD;
      end
      S_PUSH_RD, S_PUSH_CMP: begin
        cmd.push_rd  = (state == S_PUSH_RD);
        cmd.push_cmp = (state == S_PUSH_CMP);
        if ((state == S_PUSH_RD) ? status.push_root : status.push_stop) begin
          if (phase == PH_MOVED) begin
            side_next  = ~side;
            phase_next = PH_FINAL;
            state_next = S_PUSH_INIT;
          end else begin
            state_next = S_FIN_RD;
          end
        end else begin
          state_next = (state == S_PUSH_RD) ? S_PUSH_CMP : S_PUSH_RD;
        end
      end
      S_FIN_RD: begin
        cmd.fin_rd = 1'b1;
        state_next = S_FIN_CALC;
      end
      S_FIN_CALC: begin
        if (status.out_free) begin
          cmd.fin_calc = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> src/rmh_dpath.sv
// ----------------------------------------------------------------------------
// rmh_dpath
// Heap memories, sizes, sift registers, median and result register.
// ----------------------------------------------------------------------------
module rmh_dpath (
  input  logic              clk,
  input  logic              rst,
  input  rmh_pkg::sample_t  sample_data,
  input  rmh_pkg::cmd_t     cmd,
  output rmh_pkg::status_t  status,
  output logic              result_valid,
  input  logic              result_stall,
  output rmh_pkg::result_t  result_data
);
  import rmh_pkg::*;

  logic signed [31:0] lo_mem [HEAP_DEPTH];
  logic signed [31:0] up_mem [HEAP_DEPTH];
  logic signed [31:0] lo_ra, lo_rb, up_ra, up_rb;

  logic signed [31:0] x, median, median_next, val, t;
  logic [IDX_W-1:0]   lsize, usize, idx, n;
  logic               drop;

  logic [IDX_W-1:0]   size_s, raddr_a, raddr_b, waddr, parent, best;
  logic signed [31:0] wdata, rd_a, rd_b, bv;
  logic               wen, take_l, take_r;
  logic [IDX_W:0]     child_l, child_r;
  logic [COUNT_W-1:0] count;
  logic signed [32:0] sum, sum_adj;

  assign size_s  = (cmd.side == SIDE_UPPER) ? usize : lsize;
  assign rd_a    = (cmd.side == SIDE_UPPER) ? up_ra : lo_ra;
  assign rd_b    = (cmd.side == SIDE_UPPER) ? up_rb : lo_rb;
  assign child_l = {idx, 1'b1};
  assign child_r = child_l + 1'b1;
  assign parent  = IDX_W'((idx - 1'b1) >> 1);
  assign count   = COUNT_W'({1'b0, lsize}) + COUNT_W'({1'b0, usize});

  // choose the child that moves up into the hole
  always_comb begin
    take_l = (child_l < {1'b0, n}) && above(rd_a, val, cmd.side);
    best   = idx;
    bv     = val;
    if (take_l) begin
      best = child_l[IDX_W-1:0];
      bv   = rd_a;
    end
    take_r = (child_r < {1'b0, n}) && above(rd_b, bv, cmd.side);
    if (take_r) begin
      best = child_r[IDX_W-1:0];
      bv   = rd_b;
    end
  end

  // read addresses and write port
  always_comb begin
    raddr_a = '0;
    raddr_b = '0;
    wen     = 1'b0;
    waddr   = idx;
    wdata   = val;
    if (cmd.pop_top) begin
      raddr_b = size_s - 1'b1;
    end
    if (cmd.pop_rd) begin
      raddr_a = child_l[IDX_W-1:0];
      raddr_b = child_r[IDX_W-1:0];
    end
    if (cmd.pop_cmp) begin
      wen   = 1'b1;
      wdata = bv;
    end
    if (cmd.push_rd) begin
      raddr_a = parent;
      wen     = (idx == '0);
    end
    if (cmd.push_cmp) begin
      raddr_a = parent;
      wen     = 1'b1;
      wdata   = above(val, rd_a, cmd.side) ? rd_a : val;
    end
  end

  // heap memories: one write, two registered reads
  always_ff @(posedge clk) begin
    if (wen && cmd.side == SIDE_LOWER) begin
      lo_mem[waddr] <= wdata;
    end
    if (wen && cmd.side == SIDE_UPPER) begin
      up_mem[waddr] <= wdata;
    end
    lo_ra <= lo_mem[raddr_a];
    lo_rb <= lo_mem[raddr_b];
    up_ra <= up_mem[raddr_a];
    up_rb <= up_mem[raddr_b];
  end

  // even count: mean of tops truncated toward zero
  assign sum     = {lo_ra[31], lo_ra} + {up_ra[31], up_ra};
  assign sum_adj = sum + {32'b0, sum[32]};

  always_comb begin
    median_next = median;
    if (!drop) begin
      if (lsize > usize) begin
        median_next = lo_ra;
      end else if (usize > lsize) begin
        median_next = up_ra;
      end else begin
        median_next = sum_adj[32:1];
      end
    end
  end

  // sizes and median
  always_ff @(posedge clk) begin
    if (rst) begin
      lsize  <= '0;
      usize  <= '0;
      median <= '0;
    end else begin
      if (cmd.load && sample_data.new_stream) begin
        lsize  <= '0;
        usize  <= '0;
        median <= '0;
      end
      if (cmd.pop_top || cmd.push_init) begin
        if (cmd.side == SIDE_UPPER) begin
          usize <= cmd.pop_top ? usize - 1'b1 : usize + 1'b1;
        end else begin
          lsize <= cmd.pop_top ? lsize - 1'b1 : lsize + 1'b1;
        end
      end
      if (cmd.fin_calc) begin
        median <= median_next;
      end
    end
  end

  // sift registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x <= sample_data.sample;
    end
    if (cmd.decide) begin
      drop <= (count >= COUNT_W'(CAPACITY));
    end
    if (cmd.pop_load) begin
      t   <= rd_a;
      val <= rd_b;
      idx <= '0;
      n   <= size_s;
    end
    if (cmd.pop_cmp && !status.pop_done) begin
      idx <= best;
    end
    if (cmd.push_init) begin
      idx <= size_s;
      val <= cmd.push_src_t ? t : x;
    end
    if (cmd.push_cmp && !status.push_stop) begin
      idx <= parent;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.fin_calc) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_calc) begin
      result_data.running_median <= median_next;
      result_data.stored_count   <= count;
      result_data.dropped        <= drop;
    end
  end

  assign status.full      = (count >= COUNT_W'(CAPACITY));
  assign status.gt        = (x > median);
  assign status.l_gt_u    = (lsize > usize);
  assign status.u_gt_l    = (usize > lsize);
  assign status.pop_done  = !take_l && !take_r;
  assign status.push_root = (idx == '0);
  assign status.push_stop = !above(val, rd_a, cmd.side);
  assign status.out_free  = !result_valid || !result_stall;

endmodule

>>> src/running_median_two_heaps.sv
// ----------------------------------------------------------------------------
// running_median_two_heaps
// Running median of a signed 32-bit stream kept in a max-heap and a min-heap.
// ----------------------------------------------------------------------------
// One result per sample. A dropped sample goes from the decide step straight
// to the result update; a kept sample first runs its pushes and a top read.
// Each heap level takes a registered read, then a compare and write, on the
// single sift unit. A rebalancing sample runs a pop and two pushes through
// that unit one after another. A new sample is taken while the previous
// result waits on the output. The heap memories need no clearing after reset.
// ----------------------------------------------------------------------------
`include "running_median_two_heaps_defines.svh"

module running_median_two_heaps (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  rmh_pkg::sample_t sample_data,
  output logic             result_valid,
  input  logic             result_stall,
  output rmh_pkg::result_t result_data
);
  import rmh_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    count_in_range;
  logic    count_at_full;

  rmh_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .status       (status),
    .cmd          (cmd),
    .busy         (sample_stall)
  );

  rmh_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .sample_data  (sample_data),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

  assign count_in_range = (result_data.stored_count <= COUNT_W'(CAPACITY));
  assign count_at_full  = (result_data.stored_count == COUNT_W'(CAPACITY));

  // stored count stays within storage
  `RMH_ASSERT(a_count_range, result_valid |-> count_in_range)
  // a drop happens only with storage full
  `RMH_ASSERT(a_drop_full, (result_valid && result_data.dropped) |-> count_at_full)
  // no result right after reset
  `RMH_ASSERT_ALWAYS(a_reset_clear, rst |=> !result_valid)

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the running median block. Samples are sent in
// bursts, results are compared field by field against a two-heap predictor
// kept in queues, and the receiver stalls on its own random pattern.
// ----------------------------------------------------------------------------
module testbench;
  import rmh_pkg::*;

  logic    clk;
  logic    rst;
  logic    sample_valid;
  logic    sample_stall;
  sample_t sample_data;
  logic    result_valid;
  logic    result_stall;
  result_t result_data;

  // predictor state
  logic signed [31:0] low_half[$];
  logic signed [31:0] high_half[$];
  logic signed [31:0] held_median;
  result_t            median_queue[$];

  int errors = 0;
  int cycles = 0;
  int sent_count;
  int burst_left;
  int gap_left;

  localparam int CYCLE_LIMIT = 1500000;

  running_median_two_heaps DUT (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_data  (sample_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // insert into a sorted queue
  task automatic insert_sorted(ref logic signed [31:0] q[$], input logic signed [31:0] v);
    int i;
    i = 0;
    while (i < q.size() && q[i] <= v) i++;
    q.insert(i, v);
  endtask

  // compute the expected result for one accepted sample
  task automatic predict_median(input sample_t s);
    result_t            r;
    logic signed [32:0] wide_sum;
    logic signed [31:0] top_val;
    logic               was_dropped;
    was_dropped = 1'b0;
    if (s.new_stream) begin
      low_half.delete();
      high_half.delete();
      held_median = 0;
    end
    if (low_half.size() + high_half.size() >= CAPACITY) begin
      was_dropped = 1'b1;
    end else if (low_half.size() == high_half.size()) begin
      if (s.sample > held_median) begin
        insert_sorted(high_half, s.sample);
        held_median = high_half[0];
      end else begin
        insert_sorted(low_half, s.sample);
        held_median = low_half[$];
      end
    end else begin
      if (low_half.size() > high_half.size()) begin
        if (s.sample > held_median) begin
          insert_sorted(high_half, s.sample);
        end else begin
          top_val = low_half.pop_back();
          insert_sorted(high_half, top_val);
          insert_sorted(low_half, s.sample);
        end
      end else begin
        if (s.sample > held_median) begin
          top_val = high_half.pop_front();
          insert_sorted(low_half, top_val);
          insert_sorted(high_half, s.sample);
        end else begin
          insert_sorted(low_half, s.sample);
        end
      end
      // average the tops, truncate toward zero
      wide_sum = 33'(low_half[$]) + 33'(high_half[0]);
      if (wide_sum < 0) wide_sum = wide_sum + 33'sd1;
      held_median = 32'(wide_sum >>> 1);
    end
    r.running_median = held_median;
    r.stored_count   = COUNT_W'(low_half.size() + high_half.size());
    r.dropped        = was_dropped;
    median_queue.insert(median_queue.size(), r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  // send one sample, honoring burst gaps
  task automatic send_sample(input logic signed [31:0] v, input logic ns);
    while (gap_left > 0) begin
      @(posedge clk);
      gap_left--;
    end
    sample_valid <= 1'b1;
    sample_data  <= '{sample: v, new_stream: ns};
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    predict_median('{sample: v, new_stream: ns});
    sent_count++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
    end
    if (gap_left > 0) sample_valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_sample();
    case ($urandom_range(0, 5))
      0: rand_sample = 32'sh7fffffff - $urandom_range(0, 3);
      1: rand_sample = 32'sh80000000 + $urandom_range(0, 3);
      2: rand_sample = $urandom_range(0, 20) - 10;
      default: rand_sample = $urandom;
    endcase
  endfunction

  // receiver stall pattern and result check
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (median_queue.size() == 0) begin
          report_mismatch("unexpected result", result_data.running_median, 0);
        end else begin
          if (result_data.running_median !== median_queue[0].running_median)
            report_mismatch("running_median", result_data.running_median,
                            median_queue[0].running_median);
          if (result_data.stored_count !== median_queue[0].stored_count)
            report_mismatch("stored_count", 32'(result_data.stored_count),
                            32'(median_queue[0].stored_count));
          if (result_data.dropped !== median_queue[0].dropped)
            report_mismatch("dropped", 32'(result_data.dropped),
                            32'(median_queue[0].dropped));
          void'(median_queue.pop_front());
        end
      end
      result_stall <= ((cycles / 500) % 4 == 3) ? 1'b0 : ($urandom_range(0, 3) == 0);
    end
  end

  // hold the run to a limit
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic test_extremes();
    send_sample(32'sh7fffffff, 1'b1);
    send_sample(32'sh80000000, 1'b0);
    send_sample(32'sh7fffffff, 1'b0);
    send_sample(32'sh80000000, 1'b0);
    send_sample(0, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(1, 1'b0);
    send_sample(-1, 1'b1);
    send_sample(-2, 1'b0);
    send_sample(5, 1'b0);
    send_sample(5, 1'b0);
    send_sample(5, 1'b0);
    send_sample(32'sh55555555, 1'b1);
    send_sample(32'shaaaaaaaa, 1'b0);
  endtask

  task automatic test_random_streams();
    for (int i = 0; i < 436; i++)
      send_sample(rand_sample(), ($urandom_range(0, 40) == 0));
  endtask

  initial begin
    sent_count = 0;
    burst_left = 0; gap_left = 0;
    held_median = 0;
    rst = 1'b1;
    sample_valid = 1'b0;
    sample_data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_random_streams();
    sample_valid <= 1'b0;
    while (median_queue.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("sent %0d samples: extreme values, then random streams with restarts",
             sent_count);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
